// ----- hw/rtl/gb5_pkg.sv -----
// Shared types and constants of the 5x5 binomial blur.
package gb5_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANS  = 2'd2;

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // fixed field widths
    localparam int MAX_HEIGHT = 4096;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int OCOL_W     = 11;
    localparam int CHAN_W     = 2;
    localparam int CHANS_W    = 3;
    localparam int VSUM_W     = 12;
    localparam int HSUM_W     = 16;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd480;

    typedef struct packed {
        logic       cmd;
        logic [7:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        sample_out;
        logic [ROW_W-1:0]  out_row;
        logic [OCOL_W-1:0] out_col;
        logic [CHAN_W-1:0] out_channel;
        logic              frame_last;
    } t_out_item;

    // where a result lands and whether it is a border sample
    typedef struct packed {
        logic              border;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic [CHAN_W-1:0] ch;
        logic              last;
    } t_res_meta;

    // one classified item handed from front to back
    typedef struct packed {
        logic       is_sample;
        logic       emit;
        logic [7:0] sample;
        t_res_meta  meta;
    } t_op;

endpackage

// ----- hw/rtl/gaussian_blur_5x5.sv -----
// Top level of the streaming 5x5 binomial blur over interleaved 8-bit channels.
//
// Samples arrive in raster order, channel by channel, one item per clock cycle
// while o_stall is low; flush items after the frame drain the results still
// owed. Each result is registered in the queue, behind each line store, at the
// vertical sum and at the output. The rate is set by the four cascaded
// single-port line stores, each read and written once per sample. The line
// stores need no clearing pass after reset: border samples come out as zero and
// never use their contents. Configuration writes abandon a partly streamed frame.
module gaussian_blur_5x5 import gb5_pkg::*; #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_in_item              i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out_item             o_item,
    input  logic                  i_stall
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS);
    localparam int OW = $bits(t_op);
    localparam int QW = AW + OW;

    logic               push, full, pop, empty;
    t_op                f_op, q_op;
    logic [AW-1:0]      f_addr, q_addr;
    logic [QW-1:0]      q_data;
    logic [CHANS_W-1:0] chans;

    gb5_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_op       (f_op),
        .o_addr     (f_addr),
        .i_full     (full),
        .o_chans    (chans)
    );

    gb5_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_addr, f_op}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_data)
    );

    assign q_op   = t_op'(q_data[OW-1:0]);
    assign q_addr = q_data[QW-1:OW];

    gb5_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chans (chans),
        .i_valid (!empty),
        .i_op    (q_op),
        .i_addr  (q_addr),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

endmodule

// ----- hw/rtl/gb5_fifo.sv -----
// Small register queue between the front and the back of the blur.
module gb5_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count out of range");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && i_pop |=> $stable(r_count)) else $error("queue count moved");
`endif

endmodule

// ----- hw/rtl/gb5_front.sv -----
// Front of the blur: configuration, frame position counters, item classification.
module gb5_front import gb5_pkg::*; #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4,
    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_in_item              i_item,
    output logic                  o_stall,
    output logic                  o_push,
    output t_op                   o_op,
    output logic [AW-1:0]         o_addr,
    input  logic                  i_full,
    output logic [CHANS_W-1:0]    o_chans
);

    localparam int WRW   = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
    localparam int RST_C = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

    logic [WRW-1:0]      r_width,  n_width;
    logic [HEIGHT_W-1:0] r_height, n_height;
    logic [CHANS_W-1:0]  r_chans,  n_chans;

    logic [CHAN_W-1:0] r_in_ch,  n_in_ch,  e_in_ch;
    logic [CW-1:0]     r_in_col, n_in_col, e_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row, e_in_row;
    logic [AW-1:0]     r_in_lin, n_in_lin, e_in_lin;
    logic              r_in_full, n_in_full, e_in_full;
    logic [CHAN_W-1:0] r_o_ch,  n_o_ch,  e_o_ch;
    logic [CW-1:0]     r_o_col, n_o_col, e_o_col;
    logic [ROW_W-1:0]  r_o_row, n_o_row, e_o_row;
    logic              r_out_done, n_out_done, e_out_done;

    logic accept, is_sample, restart, emit, emit_ok, border;
    logic in_lch, in_lcol, in_lrow, o_lch, o_lcol, o_lrow;

    assign o_stall = i_full;
    assign o_chans = r_chans;

    // clamp configuration values
    always_comb begin
        if (i_cfg_data == '0) begin
            n_width = WRW'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            n_width = WRW'(MAX_WIDTH);
        end else begin
            n_width = WRW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            n_height = HEIGHT_W'(1);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            n_height = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            n_height = HEIGHT_W'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            n_chans = CHANS_W'(1);
        end else if (32'(i_cfg_data) > MAX_CHANNELS) begin
            n_chans = CHANS_W'(MAX_CHANNELS);
        end else begin
            n_chans = CHANS_W'(i_cfg_data);
        end
    end

    // classify the item and work out the next positions
    always_comb begin
        accept    = i_valid && !i_full;
        is_sample = (i_item.cmd == CMD_SAMPLE);
        // a sample after a complete frame opens a new frame
        restart   = is_sample && r_in_full;

        e_in_ch    = restart ? '0 : r_in_ch;
        e_in_col   = restart ? '0 : r_in_col;
        e_in_row   = restart ? '0 : r_in_row;
        e_in_lin   = restart ? '0 : r_in_lin;
        e_in_full  = restart ? 1'b0 : r_in_full;
        e_o_ch     = restart ? '0 : r_o_ch;
        e_o_col    = restart ? '0 : r_o_col;
        e_o_row    = restart ? '0 : r_o_row;
        e_out_done = restart ? 1'b0 : r_out_done;

        in_lch  = (CHANS_W'(e_in_ch) + CHANS_W'(1)) == r_chans;
        in_lcol = (WRW'(e_in_col) + WRW'(1)) == r_width;
        in_lrow = (HEIGHT_W'(e_in_row) + HEIGHT_W'(1)) == r_height;
        o_lch   = (CHANS_W'(e_o_ch) + CHANS_W'(1)) == r_chans;
        o_lcol  = (WRW'(e_o_col) + WRW'(1)) == r_width;
        o_lrow  = (HEIGHT_W'(e_o_row) + HEIGHT_W'(1)) == r_height;

        // window complete once the stream is two rows and two pixels ahead
        if (r_width == WRW'(1)) begin
            emit_ok = (e_in_row >= ROW_W'(4));
        end else begin
            emit_ok = (e_in_row >= ROW_W'(3)) ||
                      ((e_in_row == ROW_W'(2)) && (e_in_col >= CW'(2)));
        end

        border = !((e_o_row >= ROW_W'(2)) &&
                   (((HEIGHT_W+1)'(e_o_row) + (HEIGHT_W+1)'(2)) < (HEIGHT_W+1)'(r_height)) &&
                   (e_o_col >= CW'(2)) &&
                   (((WRW+1)'(e_o_col) + (WRW+1)'(2)) < (WRW+1)'(r_width)));

        emit = is_sample ? emit_ok : (r_in_full && !r_out_done);

        o_push             = accept && (is_sample || emit);
        o_op.is_sample     = is_sample;
        o_op.emit          = emit;
        o_op.sample        = i_item.sample_in;
        // drained results always lie on the border
        o_op.meta.border   = is_sample ? border : 1'b1;
        o_op.meta.row      = e_o_row;
        o_op.meta.col      = OCOL_W'(e_o_col);
        o_op.meta.ch       = e_o_ch;
        o_op.meta.last     = o_lch && o_lcol && o_lrow;
        o_addr             = e_in_lin;

        n_in_ch    = r_in_ch;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_lin   = r_in_lin;
        n_in_full  = r_in_full;
        n_o_ch     = r_o_ch;
        n_o_col    = r_o_col;
        n_o_row    = r_o_row;
        n_out_done = r_out_done;
        if (accept) begin
            n_in_ch    = e_in_ch;
            n_in_col   = e_in_col;
            n_in_row   = e_in_row;
            n_in_lin   = e_in_lin;
            n_in_full  = e_in_full;
            n_o_ch     = e_o_ch;
            n_o_col    = e_o_col;
            n_o_row    = e_o_row;
            n_out_done = e_out_done;
            if (is_sample) begin
                if (in_lch) begin
                    n_in_ch = '0;
                    if (in_lcol) begin
                        n_in_col = '0;
                        n_in_lin = '0;
                        n_in_row = e_in_row + ROW_W'(1);
                        if (in_lrow) begin
                            n_in_full = 1'b1;
                        end
                    end else begin
                        n_in_col = e_in_col + CW'(1);
                        n_in_lin = e_in_lin + AW'(1);
                    end
                end else begin
                    n_in_ch  = e_in_ch + CHAN_W'(1);
                    n_in_lin = e_in_lin + AW'(1);
                end
            end
            if (emit) begin
                if (o_lch) begin
                    n_o_ch = '0;
                    if (o_lcol) begin
                        n_o_col = '0;
                        n_o_row = e_o_row + ROW_W'(1);
                        if (o_lrow) begin
                            n_out_done = 1'b1;
                        end
                    end else begin
                        n_o_col = e_o_col + CW'(1);
                    end
                end else begin
                    n_o_ch = e_o_ch + CHAN_W'(1);
                end
            end
        end
    end

    // registers; a write to the width, height or channel register abandons the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WRW'(RST_W);
            r_height   <= RST_HEIGHT;
            r_chans    <= CHANS_W'(RST_C);
            r_in_ch    <= '0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_lin   <= '0;
            r_in_full  <= 1'b0;
            r_o_ch     <= '0;
            r_o_col    <= '0;
            r_o_row    <= '0;
            r_out_done <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_width  <= n_width;
                REG_HEIGHT: r_height <= n_height;
                REG_CHANS:  r_chans  <= n_chans;
                default: ;
            endcase
            if (i_cfg_idx == REG_WIDTH || i_cfg_idx == REG_HEIGHT ||
                i_cfg_idx == REG_CHANS) begin
                r_in_ch    <= '0;
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_lin   <= '0;
                r_in_full  <= 1'b0;
                r_o_ch     <= '0;
                r_o_col    <= '0;
                r_o_row    <= '0;
                r_out_done <= 1'b0;
            end
        end else begin
            r_in_ch    <= n_in_ch;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_lin   <= n_in_lin;
            r_in_full  <= n_in_full;
            r_o_ch     <= n_o_ch;
            r_o_col    <= n_o_col;
            r_o_row    <= n_o_row;
            r_out_done <= n_out_done;
        end
    end

endmodule

// ----- hw/rtl/gb5_back.sv -----
// Back of the blur: cascaded line stores, vertical and horizontal sums, output register.
module gb5_back import gb5_pkg::*; #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4,
    localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CHANS_W-1:0] i_chans,
    input  logic               i_valid,
    input  t_op                i_op,
    input  logic [AW-1:0]      i_addr,
    output logic               o_pop,
    output logic               o_valid,
    output t_out_item          o_item,
    input  logic               i_stall
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int HLEN  = 4 * MAX_CHANNELS;

    typedef struct packed {
        logic            valid;
        logic [AW-1:0]   addr;
        t_op             op;
        logic [4:0][7:0] col;
    } t_stg;

    t_stg stg [5];
    t_stg r_stg [1:4];
    logic [7:0] r_rd [4];

    logic [VSUM_W-1:0] vsum;
    logic [VSUM_W-1:0] r_v5;
    logic              r_s5valid;
    t_op               r_op5;
    logic [VSUM_W-1:0] r_hline [HLEN];
    logic [VSUM_W-1:0] tap [5];
    logic [HSUM_W-1:0] hsum;

    logic      en;
    logic      r_out_valid;
    t_out_item r_out;

    // the whole back advances whenever the output register can take a result
    assign en      = !r_out_valid || !i_stall;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // stage 0 is the queue head
    always_comb begin
        stg[0]        = '0;
        stg[0].valid  = i_valid;
        stg[0].addr   = i_addr;
        stg[0].op     = i_op;
        stg[0].col[0] = i_op.sample;
    end

    // four line stores in a chain; each delays its column by one row
    for (genvar k = 0; k < 4; k++) begin : g_line
        logic [7:0] r_line [DEPTH];

        always_ff @(posedge i_clk) begin
            if (en && stg[k].valid && stg[k].op.is_sample) begin
                r_rd[k]              <= r_line[stg[k].addr];
                r_line[stg[k].addr]  <= stg[k].col[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k+1] <= '0;
            end else if (en) begin
                r_stg[k+1] <= stg[k];
            end
        end

        always_comb begin
            stg[k+1]          = r_stg[k+1];
            stg[k+1].col[k+1] = r_rd[k];
        end
    end

    // vertical 1-4-6-4-1 sum over the column
    always_comb begin
        vsum = VSUM_W'(stg[4].col[0]) + (VSUM_W'(stg[4].col[1]) << 2) +
               VSUM_W'(stg[4].col[2]) * VSUM_W'(6) + (VSUM_W'(stg[4].col[3]) << 2) +
               VSUM_W'(stg[4].col[4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5valid <= 1'b0;
        end else if (en) begin
            r_s5valid <= stg[4].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op5 <= stg[4].op;
            r_v5  <= vsum;
        end
    end

    // column sums of past samples; same channel sits every channel_count taps
    always_ff @(posedge i_clk) begin
        if (en && r_s5valid && r_op5.is_sample) begin
            r_hline[0] <= r_v5;
            for (int i = 1; i < HLEN; i++) begin
                r_hline[i] <= r_hline[i-1];
            end
        end
    end

    always_comb begin
        tap[0] = r_v5;
        for (int k = 1; k < 5; k++) begin
            tap[k] = '0;
            for (int c = 1; c <= MAX_CHANNELS; c++) begin
                if (i_chans == CHANS_W'(c)) begin
                    tap[k] = r_hline[k*c-1];
                end
            end
        end
        hsum = HSUM_W'(tap[0]) + (HSUM_W'(tap[1]) << 2) + HSUM_W'(tap[2]) * HSUM_W'(6) +
               (HSUM_W'(tap[3]) << 2) + HSUM_W'(tap[4]);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s5valid && r_op5.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.sample_out  <= r_op5.meta.border ? 8'd0 : hsum[15:8];
            r_out.out_row     <= r_op5.meta.row;
            r_out.out_col     <= r_op5.meta.col;
            r_out.out_channel <= r_op5.meta.ch;
            r_out.frame_last  <= r_op5.meta.last;
        end
    end

endmodule

// ----- verif/gaussian_blur_5x5_tb.sv -----
// Self-checking testbench for the streaming 5x5 binomial blur.
`timescale 1ns / 1ps

module gaussian_blur_5x5_tb;
    import gb5_pkg::*;

    localparam int RING_SZ    = 5 * 2048 * 4;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 20;
    localparam int ITEM_GOAL  = 400;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    t_in_item              i_item = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out_item             o_item;
    logic                  i_stall = 1'b0;

    gaussian_blur_5x5 dut (.*);

    always #4 i_clk = ~i_clk;

    // blur predictor state
    logic [7:0]  line_mem [0:RING_SZ-1];
    int unsigned img_w, img_h, img_c;
    int unsigned in_pos, out_pos;
    t_out_item   blur_q[$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int frames_run = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_max = 0;
    int stall_pct = 0;
    int stall_run = 0;

    function automatic int unsigned clamp_val(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void predict_cfg(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_WIDTH:  img_w = clamp_val(d, 2048);
            REG_HEIGHT: img_h = clamp_val(d, MAX_HEIGHT);
            REG_CHANS:  img_c = clamp_val(d, 4);
            default:    return;
        endcase
        in_pos = 0;
        out_pos = 0;
    endfunction

    // compute the blurred result at out_pos and queue it
    function automatic void blur_emit();
        t_out_item   r;
        int unsigned pix, ch, row, col, acc, wy, wx, idx;
        int unsigned wts [5] = '{1, 4, 6, 4, 1};
        pix = out_pos / img_c;
        ch  = out_pos % img_c;
        row = pix / img_w;
        col = pix % img_w;
        acc = 0;
        if (row >= 2 && row + 2 < img_h && col >= 2 && col + 2 < img_w) begin
            for (int ky = 0; ky < 5; ky++) begin
                for (int kx = 0; kx < 5; kx++) begin
                    wy = row + ky - 2;
                    wx = col + kx - 2;
                    idx = ((wy * img_w + wx) * img_c + ch) % RING_SZ;
                    acc += wts[ky] * wts[kx] * line_mem[idx];
                end
            end
        end
        r.sample_out  = 8'((acc >> 8) & 8'hFF);
        r.out_row     = ROW_W'(row);
        r.out_col     = OCOL_W'(col);
        r.out_channel = CHAN_W'(ch);
        r.frame_last  = (out_pos + 1 == img_w * img_h * img_c);
        blur_q.push_back(r);
        out_pos++;
    endfunction

    function automatic void predict_item(t_in_item it);
        int unsigned total, lag;
        total = img_w * img_h * img_c;
        lag   = (2 * img_w + 2) * img_c;
        if (it.cmd == CMD_FLUSH) begin
            if (in_pos == total && out_pos < total) blur_emit();
            return;
        end
        if (in_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
        end
        line_mem[in_pos % RING_SZ] = it.sample_in;
        in_pos++;
        if (out_pos + lag <= in_pos - 1) blur_emit();
    endfunction

    // monitor: check results, then fold in accepted items and writes
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (blur_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, o_item);
                end else begin
                    e = blur_q.pop_front();
                    if (e.sample_out !== o_item.sample_out)
                        $display("%0t: sample_out exp %0d got %0d", $time,
                                 e.sample_out, o_item.sample_out);
                    if (e.out_row !== o_item.out_row)
                        $display("%0t: out_row exp %0d got %0d", $time,
                                 e.out_row, o_item.out_row);
                    if (e.out_col !== o_item.out_col)
                        $display("%0t: out_col exp %0d got %0d", $time,
                                 e.out_col, o_item.out_col);
                    if (e.out_channel !== o_item.out_channel)
                        $display("%0t: out_channel exp %0d got %0d", $time,
                                 e.out_channel, o_item.out_channel);
                    if (e.frame_last !== o_item.frame_last)
                        $display("%0t: frame_last exp %0d got %0d", $time,
                                 e.frame_last, o_item.frame_last);
                    if (e !== o_item) errors++;
                end
            end
            if (i_cfg_we) predict_cfg(i_cfg_idx, i_cfg_data);
            if (i_valid && !o_stall) predict_item(i_item);
            // watchdog on cycles where nothing moves
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no progress", $time);
                $display("gaussian_blur_5x5_tb: done, errors");
                $finish;
            end
        end
    end

    // receiver stall pattern: random stall runs
    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            stall_run--;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            i_stall <= 1'b1;
            stall_run = $urandom_range(7);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // send one item, in bursts with random gaps; starts and ends at negedge
    task automatic send_item(input logic cmd, input logic [7:0] s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= '{cmd: cmd, sample_in: s};
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // hold off until every expected result is out and the pipe is quiet
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (blur_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_shape(input int w, input int h, input int c);
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_CHANS, CFG_DATA_W'(c));
    endtask

    // stream the samples of one frame; pat 0 random, 1 extremes, 2 all 255
    task automatic stream_samples(input int n, input int pat);
        logic [7:0] s;
        for (int k = 0; k < n; k++) begin
            case (pat)
                1:       s = ($urandom_range(1)) ? 8'hFF : 8'h00;
                2:       s = 8'hFF;
                default: s = 8'($urandom_range(255));
            endcase
            send_item(CMD_SAMPLE, s);
        end
    endtask

    // drain what the frame still owes, plus spare flushes that give nothing
    task automatic flush_frame(input int spare);
        while (out_pos < img_w * img_h * img_c)
            send_item(CMD_FLUSH, 8'($urandom_range(255)));
        repeat (spare) send_item(CMD_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic run_frame(input int pat, input int spare);
        stream_samples(img_w * img_h * img_c, pat);
        flush_frame(spare);
        frames_run++;
    endtask

    // flush early at the reset shape, then abandon the frame
    task automatic test_reset_shape();
        send_item(CMD_FLUSH, 8'h00);
        stream_samples(4, 0);
        send_item(CMD_FLUSH, 8'hFF);
        wait_drained();
    endtask

    // smallest interior frame, extremes of the sample range
    task automatic test_directed();
        gap_max = 0;
        stall_pct = 0;
        set_shape(5, 5, 1);
        run_frame(1, 2);
        run_frame(2, 1);
        // unknown register index is ignored
        write_reg(REG_NONE, 13'h1FFF);
        set_shape(5, 5, 2);
        run_frame(0, 1);
    endtask

    // clamping and the extreme shapes; the widest and tallest are left partial
    task automatic test_cfg_extremes();
        gap_max = 3;
        stall_pct = 20;
        set_shape(0, 0, 0);
        run_frame(0, 1);
        set_shape(4095, 1, 1);
        stream_samples(6, 0);
        send_item(CMD_FLUSH, 8'h00);
        wait_drained();
        set_shape(1, 8191, 1);
        stream_samples(6, 0);
        send_item(CMD_FLUSH, 8'h00);
        wait_drained();
        set_shape(5, 1, 7);
        run_frame(0, 1);
    endtask

    // undrained frame followed by a new one, and a mid-frame pause
    task automatic test_frame_restart();
        set_shape(5, 5, 1);
        stream_samples(25, 0);
        send_item(CMD_FLUSH, 8'h00);
        send_item(CMD_FLUSH, 8'h00);
        run_frame(0, 0);
        stream_samples(10, 0);
        wait_drained();
        stream_samples(15, 0);
        flush_frame(1);
    endtask

    // random frames, mostly well formed, some noise and abandoned frames
    task automatic test_random();
        int n;
        while (items_sent < ITEM_GOAL) begin
            gap_max   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 60);
            set_shape($urandom_range(5, 8), $urandom_range(5, 7), $urandom_range(1, 4));
            n = img_w * img_h * img_c;
            case ($urandom_range(9))
                0: begin
                    stream_samples($urandom_range(1, n - 1), 0);
                    send_item(CMD_FLUSH, 8'($urandom_range(255)));
                    wait_drained();
                end
                1: begin
                    stream_samples(n / 2, 0);
                    send_item(CMD_FLUSH, 8'($urandom_range(255)));
                    stream_samples(n - n / 2, 0);
                    flush_frame($urandom_range(0, 2));
                end
                default: run_frame(0, $urandom_range(0, 2));
            endcase
        end
    endtask

    initial begin
        for (int k = 0; k < RING_SZ; k++) line_mem[k] = 8'h00;
        img_w = 640;
        img_h = RST_HEIGHT;
        img_c = 3;
        in_pos = 0;
        out_pos = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_shape();
        test_directed();
        test_cfg_extremes();
        test_frame_restart();
        test_random();
        stall_pct = 0;
        wait_drained();
        $display("ran %0d items over %0d frames, %0d results checked", items_sent,
                 frames_run, results_seen);
        $display("covered clamped shapes, early and spare flushes, restarts");
        if (errors == 0 && blur_q.size() == 0)
            $display("gaussian_blur_5x5_tb: done, clean");
        else
            $display("gaussian_blur_5x5_tb: done, errors");
        $finish;
    end

endmodule
